// ===== src/assert_macros.svh =====
// Assertion macros used by the top-level RTL file of the 3x3 convolution block.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside of reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never be true outside of reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== src/c3d9_pkg.sv =====
// Package of the 3x3 convolution block: sizes, register indexes, pixel and tag types
// and the column weighting function. Depends on nothing.
package c3d9_pkg;

  localparam int unsigned MaxWidth  = 1024;
  localparam int unsigned AddrW     = $clog2(MaxWidth);
  localparam int unsigned PixW      = 8;
  localparam int unsigned ColSumW   = 18;
  localparam int unsigned TotalW    = 20;
  localparam int unsigned AbsW      = TotalW - 1;
  localparam int unsigned RecipShift = 22;
  localparam int unsigned RecipW    = 19;
  // ceil(2^22 / 9): exact floor division by nine for every value below 2^21.
  localparam logic [RecipW-1:0] Recip9 = RecipW'(((1 << RecipShift) + 8) / 9);

  typedef enum logic [2:0] {
    REG_KERNEL_ROW_TOP    = 3'd0,
    REG_KERNEL_ROW_MID    = 3'd1,
    REG_KERNEL_ROW_BOTTOM = 3'd2,
    REG_IMAGE_ROWS        = 3'd3,
    REG_IMAGE_COLS        = 3'd4
  } cfg_reg_e;

  // One window column: pixel two rows above, one row above, current row.
  typedef struct packed {
    logic [PixW-1:0] top;
    logic [PixW-1:0] mid;
    logic [PixW-1:0] bot;
  } pix_col_t;

  // The three kernel coefficients that weight one window column.
  typedef struct packed {
    logic signed [7:0] top;
    logic signed [7:0] mid;
    logic signed [7:0] bot;
  } coef_col_t;

  // Position information that travels with a result.
  typedef struct packed {
    logic [15:0] row;
    logic [9:0]  col;
    logic        done;
  } tag_t;

  function automatic logic signed [ColSumW-1:0] col_sum(pix_col_t p, coef_col_t k);
    logic signed [16:0] pt;
    logic signed [16:0] pm;
    logic signed [16:0] pb;
    pt = $signed({1'b0, p.top}) * k.top;
    pm = $signed({1'b0, p.mid}) * k.mid;
    pb = $signed({1'b0, p.bot}) * k.bot;
    return ColSumW'(pt) + ColSumW'(pm) + ColSumW'(pb);
  endfunction

endpackage

// ===== src/convolution_3x3_div9_top.sv =====
// 3x3 convolution of a raster pixel stream with a signed kernel, divided by nine.
// Pixels arrive in raster order; one pixel is accepted per clock while results are
// taken. The datapath has five register stages: line store read, weighted column sums,
// then three divide stages. The first stage is loaded by the edge that accepts a pixel;
// an interior result then passes stage 2 and the three divide stages. A 1024 x 16 line
// store read once and written once per pixel holds the two rows above; a chain of two
// column cells holds the two columns to the left. Border positions produce no result.
// Configuration must be written only while idle; the block does not enforce this.
// Depends on c3d9_pkg, c3d9_line_ram, c3d9_col_cell, c3d9_div9 and assert_macros.svh.
`include "assert_macros.svh"

module convolution_3x3_div9_top
  import c3d9_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // Configuration write port.
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [23:0]        cfg_wdata_i,
  // Pixel requests.
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         pixel_i,
  // Result requests.
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] filtered_value_o,
  output logic [15:0]        out_row_o,
  output logic [9:0]         out_col_o,
  output logic               frame_done_o
);

  // Configuration registers.
  logic [23:0] kernel_row_top_q, kernel_row_mid_q, kernel_row_bottom_q;
  logic [15:0] image_rows_q;
  logic [10:0] image_cols_q;

  // Position of the next pixel.
  logic [15:0]      row_count_q;
  logic [AddrW-1:0] col_count_q;

  // Stage 1: pixel waiting for its line store data.
  logic             s1_valid_q;
  logic             s1_interior_q;
  logic [7:0]       s1_pixel_q;
  logic [AddrW-1:0] s1_idx_q;
  tag_t             s1_tag_q;

  // Stage 2: weighted column sums of one interior window.
  logic                      s2_valid_q;
  logic signed [ColSumW-1:0] s2_sum0_q, s2_sum1_q, s2_sum2_q;
  tag_t                      s2_tag_q;

  logic        in_fire, s1_ready, s1_fire, s2_ready, div_ready;
  logic [15:0] eff_rows;
  logic [10:0] eff_cols;
  logic [16:0] row_next;
  logic [10:0] col_next;
  logic        interior_d;
  tag_t        tag_d;
  logic [15:0] line_rdata;
  pix_col_t    cur_col, cell1_col, cell0_col;
  coef_col_t   coef0, coef1, coef2;
  logic signed [ColSumW-1:0] sum0, sum1, sum2;
  logic signed [TotalW-1:0]  total;
  tag_t        out_tag;
  logic        unused_cell0;

  // Effective frame size: rows at least three, columns between three and the store depth.
  assign eff_rows = (image_rows_q < 16'd3) ? 16'd3 : image_rows_q;
  assign eff_cols = (image_cols_q < 11'd3) ? 11'd3 :
                    (image_cols_q > 11'(MaxWidth)) ? 11'(MaxWidth) : image_cols_q;

  assign row_next = {1'b0, row_count_q} + 17'd1;
  assign col_next = {1'b0, col_count_q} + 11'd1;

  // A position is interior when the full 3x3 neighborhood ends at this pixel.
  assign interior_d = (row_count_q >= 16'd2) && (col_count_q >= AddrW'(2)) &&
                      (row_next <= {1'b0, eff_rows}) && (col_next <= eff_cols);
  assign tag_d.row  = 16'(row_count_q - 16'd1);
  assign tag_d.col  = 10'(col_count_q - AddrW'(1));
  assign tag_d.done = (row_next == {1'b0, eff_rows}) && (col_next == eff_cols);

  // Handshake chain. A stage-1 pixel that is not interior leaves without a result,
  // so it never waits on the arithmetic behind it.
  assign s2_ready   = !s2_valid_q || div_ready;
  assign s1_ready   = !s1_valid_q || !s1_interior_q || s2_ready;
  assign s1_fire    = s1_valid_q && s1_ready;
  assign in_ready_o = s1_ready;
  assign in_fire    = in_valid_i && s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kernel_row_top_q    <= '0;
      kernel_row_mid_q    <= '0;
      kernel_row_bottom_q <= '0;
      image_rows_q        <= 16'd3;
      image_cols_q        <= 11'd3;
      row_count_q         <= '0;
      col_count_q         <= '0;
      s1_valid_q          <= 1'b0;
      s2_valid_q          <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_KERNEL_ROW_TOP:    kernel_row_top_q    <= cfg_wdata_i;
          REG_KERNEL_ROW_MID:    kernel_row_mid_q    <= cfg_wdata_i;
          REG_KERNEL_ROW_BOTTOM: kernel_row_bottom_q <= cfg_wdata_i;
          REG_IMAGE_ROWS:        image_rows_q        <= cfg_wdata_i[15:0];
          REG_IMAGE_COLS:        image_cols_q        <= cfg_wdata_i[10:0];
          default: ;
        endcase
      end
      // Raster position: wrap the column at the row end and the row at the frame end.
      if (in_fire) begin
        if (col_next >= eff_cols) begin
          col_count_q <= '0;
          row_count_q <= (row_next >= {1'b0, eff_rows}) ? 16'd0 : row_next[15:0];
        end else begin
          col_count_q <= col_next[AddrW-1:0];
        end
      end
      if (s1_ready) s1_valid_q <= in_valid_i;
      if (s2_ready) s2_valid_q <= s1_fire && s1_interior_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_pixel_q    <= pixel_i;
      s1_idx_q      <= col_count_q;
      s1_interior_q <= interior_d;
      s1_tag_q      <= tag_d;
    end
    if (s2_ready && s1_fire && s1_interior_q) begin
      s2_sum0_q <= sum0;
      s2_sum1_q <= sum1;
      s2_sum2_q <= sum2;
      s2_tag_q  <= s1_tag_q;
    end
  end

  // The line store is read when a pixel is accepted and rewritten when that pixel
  // leaves stage 1; the next read of the same column comes at least three pixels
  // later, so the write has always landed by then.
  c3d9_line_ram #(
    .Depth (MaxWidth),
    .Width (16)
  ) u_line_ram (
    .clk_i     (clk_i),
    .wr_en_i   (s1_fire),
    .wr_addr_i (s1_idx_q),
    .wr_data_i ({cur_col.mid, s1_pixel_q}),
    .rd_en_i   (in_fire),
    .rd_addr_i (col_count_q),
    .rd_data_o (line_rdata)
  );

  assign cur_col.top = line_rdata[15:8];
  assign cur_col.mid = line_rdata[7:0];
  assign cur_col.bot = s1_pixel_q;

  // Kernel column k takes byte k of each kernel row register.
  assign coef0 = '{top: kernel_row_top_q[7:0],   mid: kernel_row_mid_q[7:0],
                   bot: kernel_row_bottom_q[7:0]};
  assign coef1 = '{top: kernel_row_top_q[15:8],  mid: kernel_row_mid_q[15:8],
                   bot: kernel_row_bottom_q[15:8]};
  assign coef2 = '{top: kernel_row_top_q[23:16], mid: kernel_row_mid_q[23:16],
                   bot: kernel_row_bottom_q[23:16]};

  // Window chain: the current column enters cell 1, which hands its column to cell 0.
  c3d9_col_cell u_cell1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .shift_i (s1_fire),
    .col_i   (cur_col),
    .coef_i  (coef1),
    .col_o   (cell1_col),
    .sum_o   (sum1)
  );

  c3d9_col_cell u_cell0 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .shift_i (s1_fire),
    .col_i   (cell1_col),
    .coef_i  (coef0),
    .col_o   (cell0_col),
    .sum_o   (sum0)
  );

  assign sum2  = col_sum(cur_col, coef2);
  assign total = TotalW'(s2_sum0_q) + TotalW'(s2_sum1_q) + TotalW'(s2_sum2_q);

  c3d9_div9 u_div9 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s2_valid_q),
    .ready_o (div_ready),
    .value_i (total),
    .tag_i   (s2_tag_q),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .value_o (filtered_value_o),
    .tag_o   (out_tag)
  );

  assign out_row_o    = out_tag.row;
  assign out_col_o    = out_tag.col;
  assign frame_done_o = out_tag.done;

  // The line store write of a held pixel must happen before any new pixel enters.
  `ASSERT_CLK(a_no_overtake, in_fire |-> !(s1_valid_q && !s1_fire),
              "pixel accepted while stage 1 is held")
  // An interior pixel leaving stage 1 always becomes a pending column sum.
  `ASSERT_CLK(a_interior_kept, (s1_fire && s1_interior_q) |=> s2_valid_q,
              "interior window dropped")
  // Results are interior positions only.
  `ASSERT_NEVER(a_out_border, out_valid_o && (out_row_o == 16'd0 || out_col_o == 10'd0),
                "result on a border position")

  // cell 0 passes its column on to nothing further; keep its output observed.
  assign unused_cell0 = ^cell0_col;

endmodule

// ===== src/c3d9_line_ram.sv =====
// Generic single-write, single-read memory with registered read data.
// Used for the line store of the 3x3 convolution block; no dependencies.
module c3d9_line_ram #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned Width = 16,
  localparam int unsigned AW   = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [Width-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [Width-1:0] rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== src/c3d9_col_cell.sv =====
// One cell of the window chain: holds one pixel column, passes it on to its
// neighbor on each shift and weights it with its kernel column. Uses c3d9_pkg.
module c3d9_col_cell
  import c3d9_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      shift_i,
  input  pix_col_t                  col_i,
  input  coef_col_t                 coef_i,
  output pix_col_t                  col_o,
  output logic signed [ColSumW-1:0] sum_o
);

  pix_col_t col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else if (shift_i) begin
      col_q <= col_i;
    end
  end

  assign col_o = col_q;
  assign sum_o = col_sum(col_q, coef_i);

endmodule

// ===== src/c3d9_div9.sv =====
// Pipelined divide-by-nine, truncating toward zero, with a tag carried along.
// Three stages: magnitude, reciprocal multiply, sign restore. Uses c3d9_pkg.
module c3d9_div9
  import c3d9_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  output logic                     ready_o,
  input  logic signed [TotalW-1:0] value_i,
  input  tag_t                     tag_i,
  output logic                     valid_o,
  input  logic                     ready_i,
  output logic signed [15:0]       value_o,
  output tag_t                     tag_o
);

  logic                         a_valid_q, b_valid_q, c_valid_q;
  logic                         a_ready, b_ready, c_ready;
  logic [AbsW-1:0]              a_abs_q;
  logic                         a_neg_q, b_neg_q;
  tag_t                         a_tag_q, b_tag_q, c_tag_q;
  logic [15:0]                  b_quot_q;
  logic signed [15:0]           c_value_q;
  logic [AbsW-1:0]              abs_d;
  logic [AbsW+RecipW-1:0]       prod;
  logic [15:0]                  quot_d;

  assign c_ready = !c_valid_q || ready_i;
  assign b_ready = !b_valid_q || c_ready;
  assign a_ready = !a_valid_q || b_ready;
  assign ready_o = a_ready;

  assign abs_d  = value_i[TotalW-1] ? AbsW'(-value_i) : AbsW'(value_i);
  assign prod   = {{RecipW{1'b0}}, a_abs_q} * {{AbsW{1'b0}}, Recip9};
  assign quot_d = 16'(prod >> RecipShift);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else begin
      if (a_ready) a_valid_q <= valid_i;
      if (b_ready) b_valid_q <= a_valid_q;
      if (c_ready) c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready && valid_i) begin
      a_abs_q <= abs_d;
      a_neg_q <= value_i[TotalW-1];
      a_tag_q <= tag_i;
    end
    if (b_ready && a_valid_q) begin
      b_quot_q <= quot_d;
      b_neg_q  <= a_neg_q;
      b_tag_q  <= a_tag_q;
    end
    if (c_ready && b_valid_q) begin
      c_value_q <= b_neg_q ? -$signed(b_quot_q) : $signed(b_quot_q);
      c_tag_q   <= b_tag_q;
    end
  end

  assign valid_o = c_valid_q;
  assign value_o = c_value_q;
  assign tag_o   = c_tag_q;

endmodule

// ===== sim/convolution_3x3_div9_top_tb.sv =====
// Self-checking testbench for convolution_3x3_div9_top: directed frames, then random
// frames with mid-frame size and kernel changes, all scored by a local model of the
// filter. Depends on c3d9_pkg and the RTL of the block.
module convolution_3x3_div9_top_tb;
  import c3d9_pkg::*;

  localparam int unsigned ClkPeriod   = 10;
  localparam int unsigned DrainCycles = 16;      // pipeline is five deep, allow margin
  localparam int unsigned CycleLimit  = 600_000;
  localparam int unsigned RandItems   = 700;
  localparam int unsigned MinSize     = 3;       // smallest frame edge the block accepts
  localparam int          Divisor     = 9;

  // One filtered position as seen on the result port.
  typedef struct packed {
    logic signed [15:0] value;
    logic [15:0]        row;
    logic [9:0]         col;
    logic               done;
  } conv_result_t;

  // How far a line-store entry has been filled since reset. An entry is only fully
  // known after its second write, because the first write copies an unknown byte.
  typedef enum bit [1:0] {FILL_NONE, FILL_MID, FILL_FULL} fill_e;

  typedef enum logic {DIR_PIXEL, DIR_WRITE} dir_kind_e;

  typedef struct packed {
    dir_kind_e    kind;
    cfg_reg_e     reg_sel;   // only meaningful for register writes
    logic [23:0]  wdata;
    logic [7:0]   px;
    logic         typed;     // the row carries a hand-computed expectation
    conv_result_t want;
  } dir_step_t;

  localparam conv_result_t NoResult = '0;

  // Three 3x3 frames: all-zero kernel after reset, then the most negative and the most
  // positive kernels on a white frame. The last frame also writes sizes below three,
  // which must behave as a 3x3 frame.
  localparam dir_step_t DirTable [35] = '{
    '{DIR_PIXEL, REG_KERNEL_ROW_TOP,    24'h0,      8'h00, 1'b0, NoResult},
    '{DIR_PIXEL, REG_KERNEL_ROW_TOP,    24'h0,      8'hFF, 1'b0, NoResult},
    '{DIR_PIXEL, REG_KERNEL_ROW_TOP,    24'h0,      8'h01, 1'b0, NoResult},
    '{DIR_PIXEL, REG_KERNEL_ROW_TOP,    24'h0,      8'h80, 1'b0, NoResult},
    '{DIR_PIXEL, REG_KERNEL_ROW_TOP,    24'h0,      8'h7F, 1'b0, NoResult},
    '{DIR_PIXEL, REG_KERNEL_ROW_TOP,    24'h0,      8'hAA, 1'b0, NoResult},
    '{DIR_PIXEL, REG_KERNEL_ROW_TOP,    24'h0,      8'h55, 1'b0, NoResult},
    '{DIR_PIXEL, REG_KERNEL_ROW_TOP,    24'h0,      8'hFE, 1'b0, NoResult},
    '{DIR_PIXEL, REG_KERNEL_ROW_TOP,    24'h0,      8'h12, 1'b1,
      '{16'sd0, 16'd1, 10'd1, 1'b1}},
    '{DIR_WRITE, REG_KERNEL_ROW_TOP,    24'h808080, 8'h00, 1'b0, NoResult},
    '{DIR_WRITE, REG_KERNEL_ROW_MID,    24'h808080, 8'h00, 1'b0, NoResult},
    '{DIR_WRITE, REG_KERNEL_ROW_BOTTOM, 24'h808080, 8'h00, 1'b0, NoResult},
    '{DIR_PIXEL, REG_KERNEL_ROW_TOP,    24'h0,      8'hFF, 1'b0, NoResult},
    '{DIR_PIXEL, REG_KERNEL_ROW_TOP,    24'h0,      8'hFF, 1'b0, NoResult},
    '{DIR_PIXEL, REG_KERNEL_ROW_TOP,    24'h0,      8'hFF, 1'b0, NoResult},
    '{DIR_PIXEL, REG_KERNEL_ROW_TOP,    24'h0,      8'hFF, 1'b0, NoResult},
    '{DIR_PIXEL, REG_KERNEL_ROW_TOP,    24'h0,      8'hFF, 1'b0, NoResult},
    '{DIR_PIXEL, REG_KERNEL_ROW_TOP,    24'h0,      8'hFF, 1'b0, NoResult},
    '{DIR_PIXEL, REG_KERNEL_ROW_TOP,    24'h0,      8'hFF, 1'b0, NoResult},
    '{DIR_PIXEL, REG_KERNEL_ROW_TOP,    24'h0,      8'hFF, 1'b0, NoResult},
    '{DIR_PIXEL, REG_KERNEL_ROW_TOP,    24'h0,      8'hFF, 1'b1,
      '{-16'sd32640, 16'd1, 10'd1, 1'b1}},
    '{DIR_WRITE, REG_KERNEL_ROW_TOP,    24'h7F7F7F, 8'h00, 1'b0, NoResult},
    '{DIR_WRITE, REG_KERNEL_ROW_MID,    24'h7F7F7F, 8'h00, 1'b0, NoResult},
    '{DIR_WRITE, REG_KERNEL_ROW_BOTTOM, 24'h7F7F7F, 8'h00, 1'b0, NoResult},
    '{DIR_WRITE, REG_IMAGE_ROWS,        24'h000000, 8'h00, 1'b0, NoResult},
    '{DIR_WRITE, REG_IMAGE_COLS,        24'h000001, 8'h00, 1'b0, NoResult},
    '{DIR_PIXEL, REG_KERNEL_ROW_TOP,    24'h0,      8'hFF, 1'b0, NoResult},
    '{DIR_PIXEL, REG_KERNEL_ROW_TOP,    24'h0,      8'hFF, 1'b0, NoResult},
    '{DIR_PIXEL, REG_KERNEL_ROW_TOP,    24'h0,      8'hFF, 1'b0, NoResult},
    '{DIR_PIXEL, REG_KERNEL_ROW_TOP,    24'h0,      8'hFF, 1'b0, NoResult},
    '{DIR_PIXEL, REG_KERNEL_ROW_TOP,    24'h0,      8'hFF, 1'b0, NoResult},
    '{DIR_PIXEL, REG_KERNEL_ROW_TOP,    24'h0,      8'hFF, 1'b0, NoResult},
    '{DIR_PIXEL, REG_KERNEL_ROW_TOP,    24'h0,      8'hFF, 1'b0, NoResult},
    '{DIR_PIXEL, REG_KERNEL_ROW_TOP,    24'h0,      8'hFF, 1'b0, NoResult},
    '{DIR_PIXEL, REG_KERNEL_ROW_TOP,    24'h0,      8'hFF, 1'b1,
      '{16'sd32385, 16'd1, 10'd1, 1'b1}}
  };

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [2:0]         cfg_index_i;
  logic [23:0]        cfg_wdata_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [7:0]         pixel_i;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [15:0] filtered_value_o;
  logic [15:0]        out_row_o;
  logic [9:0]         out_col_o;
  logic               frame_done_o;

  convolution_3x3_div9_top dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .pixel_i          (pixel_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .filtered_value_o (filtered_value_o),
    .out_row_o        (out_row_o),
    .out_col_o        (out_col_o),
    .frame_done_o     (frame_done_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Filter model: register copies, line store, two-column window and raster
  // position, updated once for every pixel the block accepts.
  // ---------------------------------------------------------------------------
  bit [23:0]   kern_top, kern_mid, kern_bot;
  bit [15:0]   rows_reg;
  bit [10:0]   cols_reg;
  bit [15:0]   line_mem [MaxWidth];   // {two rows above, one row above} per column
  fill_e       line_fill [MaxWidth];
  bit [7:0]    win_px [6];            // column c-2 then c-1, each top, mid, bottom
  int unsigned row_pos, col_pos;

  conv_result_t pending_results [$];
  int unsigned  errors;
  bit           gaps_on;              // random idling on both channels
  int unsigned  ready_hold;

  function automatic int unsigned clamp_rows(bit [15:0] v);
    return (v < MinSize) ? MinSize : v;
  endfunction

  function automatic int unsigned clamp_cols(bit [10:0] v);
    if (v < MinSize) return MinSize;
    if (v > MaxWidth) return MaxWidth;
    return v;
  endfunction

  function automatic void apply_reg(logic [2:0] idx, logic [23:0] data);
    case (idx)
      REG_KERNEL_ROW_TOP:    kern_top = data;
      REG_KERNEL_ROW_MID:    kern_mid = data;
      REG_KERNEL_ROW_BOTTOM: kern_bot = data;
      REG_IMAGE_ROWS:        rows_reg = data[15:0];
      REG_IMAGE_COLS:        cols_reg = data[10:0];
      default: ;             // unmapped indexes are ignored
    endcase
  endfunction

  // One kernel row applied to three pixels, left column weighted by the low byte.
  function automatic int row_dot(bit [23:0] coefs, bit [7:0] left, bit [7:0] center,
                                 bit [7:0] right);
    int k0, k1, k2;
    k0 = $signed(coefs[7:0]);
    k1 = $signed(coefs[15:8]);
    k2 = $signed(coefs[23:16]);
    return k0 * int'(left) + k1 * int'(center) + k2 * int'(right);
  endfunction

  // True when entries below n have all been written twice, so growing the row
  // width mid-frame only exposes defined (if stale) line-store data.
  function automatic bit store_primed(int unsigned n);
    for (int unsigned j = 0; j < n; j++) begin
      if (line_fill[j] != FILL_FULL) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic bit filter_pixel(input bit [7:0] px, output conv_result_t res);
    int unsigned n_rows, n_cols, idx;
    bit [7:0]    up2, up1;
    int          acc;
    bit          interior;
    n_rows   = clamp_rows(rows_reg);
    n_cols   = clamp_cols(cols_reg);
    idx      = (col_pos < MaxWidth) ? col_pos : MaxWidth - 1;
    {up2, up1} = line_mem[idx];
    interior = row_pos >= 2 && col_pos >= 2 && row_pos + 1 <= n_rows &&
               col_pos + 1 <= n_cols;
    res = '0;
    if (interior) begin
      acc = row_dot(kern_top, win_px[0], win_px[3], up2) +
            row_dot(kern_mid, win_px[1], win_px[4], up1) +
            row_dot(kern_bot, win_px[2], win_px[5], px);
      res.value = 16'(acc / Divisor);
      res.row   = 16'(row_pos - 1);
      res.col   = 10'(col_pos - 1);
      res.done  = (row_pos + 1 == n_rows) && (col_pos + 1 == n_cols);
    end
    win_px[0] = win_px[3];
    win_px[1] = win_px[4];
    win_px[2] = win_px[5];
    win_px[3] = up2;
    win_px[4] = up1;
    win_px[5] = px;
    line_mem[idx]  = {up1, px};
    line_fill[idx] = (line_fill[idx] == FILL_NONE) ? FILL_MID : FILL_FULL;
    col_pos++;
    if (col_pos >= n_cols) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= n_rows) row_pos = 0;
    end
    return interior;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers. Inputs change on the falling edge only; handshakes are
  // sampled on the rising edge.
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] rand_pixel();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Coefficients lean toward the extremes and the signs near zero.
  function automatic logic [23:0] rand_coefs();
    logic [23:0] w;
    for (int k = 0; k < 3; k++) begin
      case ($urandom_range(0, 5))
        0:       w[8*k +: 8] = 8'h80;
        1:       w[8*k +: 8] = 8'h7F;
        2:       w[8*k +: 8] = 8'hFF;
        3:       w[8*k +: 8] = 8'h01;
        default: w[8*k +: 8] = 8'($urandom);
      endcase
    end
    return w;
  endfunction

  // Offers one pixel request, holds it until accepted and records what it should
  // produce. A typed expectation replaces the model's where the table gives one.
  task automatic send_pixel(input logic [7:0] px, input bit typed,
                            input conv_result_t want);
    conv_result_t got;
    bit           produced;
    @(negedge clk_i);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    pixel_i    <= px;
    do @(posedge clk_i); while (!in_ready_o);
    produced = filter_pixel(px, got);
    if (typed) pending_results.push_back(want);
    else if (produced) pending_results.push_back(got);
  endtask

  // Stops sending and waits until every expected result has been taken, then
  // lets the pipeline drain of positions that yield nothing.
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [23:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    apply_reg(idx, data);
  endtask

  task automatic end_writes();
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // The result side stalls in bursts while idling is enabled.
  always @(negedge clk_i) begin
    if (ready_hold != 0) begin
      ready_hold--;
      out_ready_i <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 7) == 0) begin
      ready_hold = $urandom_range(0, 9);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Every accepted result is matched against the oldest outstanding expectation.
  always @(posedge clk_i) begin : result_check
    conv_result_t exp_res;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: value %0d row %0d col %0d done %0b",
               filtered_value_o, out_row_o, out_col_o, frame_done_o);
        errors++;
      end else begin
        exp_res = pending_results.pop_front();
        if (filtered_value_o !== exp_res.value) begin
          $error("filtered_value: expected %0d, got %0d", $signed(exp_res.value),
                 filtered_value_o);
          errors++;
        end
        if (out_row_o !== exp_res.row) begin
          $error("out_row: expected %0d, got %0d", exp_res.row, out_row_o);
          errors++;
        end
        if (out_col_o !== exp_res.col) begin
          $error("out_col: expected %0d, got %0d", exp_res.col, out_col_o);
          errors++;
        end
        if (frame_done_o !== exp_res.done) begin
          $error("frame_done: expected %0b, got %0b", exp_res.done, frame_done_o);
          errors++;
        end
      end
    end
  end

  // Hard stop in case the block hangs.
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    int unsigned rand_sent, burst, want_rows, want_cols, n, wait_cycles;
    logic [23:0] wdata;
    bit          in_writes, to_frame_end;

    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_index_i = '0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    pixel_i     = '0;
    rows_reg    = 16'(MinSize);
    cols_reg    = 11'(MinSize);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed frames. Register rows are grouped, and each group waits for the
    // block to be idle before the first write goes out.
    gaps_on   = 1'b1;
    in_writes = 1'b0;
    foreach (DirTable[i]) begin
      if (DirTable[i].kind == DIR_WRITE) begin
        if (!in_writes) wait_idle();
        in_writes = 1'b1;
        write_reg(DirTable[i].reg_sel, DirTable[i].wdata);
      end else begin
        if (in_writes) end_writes();
        in_writes = 1'b0;
        send_pixel(DirTable[i].px, DirTable[i].typed, DirTable[i].want);
      end
    end

    // Random phases. Each phase pauses until the block is idle, rewrites some
    // registers and then sends a burst that often stops mid-frame, so later size
    // changes land at arbitrary raster positions. The last stretch runs with no
    // idling on either side.
    rand_sent = 0;
    while (rand_sent < RandItems) begin
      gaps_on = (RandItems - rand_sent > 120) && ($urandom_range(0, 3) != 0);
      wait_idle();
      if ($urandom_range(0, 1) == 0) write_reg(REG_KERNEL_ROW_TOP, rand_coefs());
      if ($urandom_range(0, 1) == 0) write_reg(REG_KERNEL_ROW_MID, rand_coefs());
      if ($urandom_range(0, 1) == 0) write_reg(REG_KERNEL_ROW_BOTTOM, rand_coefs());
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 9))
          0:       want_rows = $urandom_range(0, MinSize - 1);
          1:       want_rows = 16'hFFFF;
          default: want_rows = $urandom_range(MinSize, 8);
        endcase
        wdata = 24'(want_rows);
        if ($urandom_range(0, 3) == 0) wdata[23:16] = 8'($urandom);
        write_reg(REG_IMAGE_ROWS, wdata);
      end
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 9))
          0:       want_cols = $urandom_range(0, MinSize - 1);
          1:       want_cols = $urandom_range(MaxWidth + 1, 2047);
          default: want_cols = $urandom_range(MinSize, 12);
        endcase
        // A wider row mid-frame is only allowed once the store is filled that far.
        if ((row_pos == 0 && col_pos == 0) ||
            clamp_cols(11'(want_cols)) <= clamp_cols(cols_reg) ||
            store_primed(clamp_cols(11'(want_cols)))) begin
          wdata = 24'(want_cols);
          if ($urandom_range(0, 3) == 0) wdata[23:11] = 13'($urandom);
          write_reg(REG_IMAGE_COLS, wdata);
        end
      end
      if ($urandom_range(0, 15) == 0) begin
        write_reg(3'($urandom_range(REG_IMAGE_COLS + 1, (1 << $bits(cfg_index_i)) - 1)),
                  24'($urandom));
      end
      end_writes();

      to_frame_end = (clamp_rows(rows_reg) * clamp_cols(cols_reg) <= 150) &&
                     ($urandom_range(0, 2) == 0);
      burst = to_frame_end ? 400 : $urandom_range(1, 40);
      for (n = 0; n < burst; n++) begin
        send_pixel(rand_pixel(), 1'b0, NoResult);
        rand_sent++;
        if (to_frame_end && row_pos == 0 && col_pos == 0) break;
      end
    end

    // Let every outstanding result arrive, then give trailing positions time.
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait_cycles = 0;
    while (pending_results.size() != 0 && wait_cycles < 5000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (DrainCycles) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      errors++;
    end
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
